/* rtl/iir8_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// iir8_pkg
// Shared types and constants of the eighth-order band-pass IIR filter.
// ----------------------------------------------------------------------------
package iir8_pkg;

   localparam int STATE_WIDTH = 32;
   localparam int COEF_WIDTH  = 24;

   localparam int SAMPLE_WIDTH   = 16;
   localparam int FILTERED_WIDTH = 32;
   localparam int GAIN_WIDTH     = 32;
   localparam int PAIR_WIDTH     = 2 * COEF_WIDTH;
   localparam int CSR_DATA_WIDTH = (PAIR_WIDTH > GAIN_WIDTH) ? PAIR_WIDTH : GAIN_WIDTH;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int HIST_DEPTH     = 8;
   localparam int HIST_IDX_WIDTH = $clog2(HIST_DEPTH);

   localparam int MUL_B_WIDTH = (COEF_WIDTH > GAIN_WIDTH + 1) ? COEF_WIDTH : GAIN_WIDTH + 1;
   localparam int PROD_WIDTH  = STATE_WIDTH + MUL_B_WIDTH;
   localparam int ACC_WIDTH   = 64;
   localparam int EXT_WIDTH   = (PROD_WIDTH > ACC_WIDTH) ? PROD_WIDTH : ACC_WIDTH;
   localparam int FRAC_SHIFT  = 16;
   localparam int SCALE_SHIFT = 14;

   localparam logic signed [PROD_WIDTH-1:0] ROUND_BIAS = PROD_WIDTH'(8192);

   localparam logic signed [STATE_WIDTH-1:0] STATE_MAX = {1'b0, {(STATE_WIDTH-1){1'b1}}};
   localparam logic signed [STATE_WIDTH-1:0] STATE_MIN = {1'b1, {(STATE_WIDTH-1){1'b0}}};

   localparam logic signed [ACC_WIDTH-1:0] OUT_MAX =
      {{(ACC_WIDTH-FILTERED_WIDTH+1){1'b0}}, {(FILTERED_WIDTH-1){1'b1}}};
   localparam logic signed [ACC_WIDTH-1:0] OUT_MIN =
      {{(ACC_WIDTH-FILTERED_WIDTH+1){1'b1}}, {(FILTERED_WIDTH-1){1'b0}}};

   localparam logic signed [3:0] TAP_ONE        = 4'sd1;
   localparam logic signed [3:0] TAP_MINUS_FOUR = -4'sd4;
   localparam logic signed [3:0] TAP_SIX        = 4'sd6;

   localparam logic [GAIN_WIDTH-1:0] INV_GAIN_RESET = 32'h4000_0000;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_COEF_PAIR_0 = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_COEF_PAIR_1 = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_COEF_PAIR_2 = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_COEF_PAIR_3 = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_INV_GAIN    = 3'd4;

   localparam int STEP_WIDTH = 4;
   localparam logic [STEP_WIDTH-1:0] STEP_SCALE    = 4'd0;
   localparam logic [STEP_WIDTH-1:0] STEP_TAP_X8   = 4'd1;
   localparam logic [STEP_WIDTH-1:0] STEP_TAP_X2   = 4'd2;
   localparam logic [STEP_WIDTH-1:0] STEP_TAP_X6   = 4'd3;
   localparam logic [STEP_WIDTH-1:0] STEP_TAP_X4   = 4'd4;
   localparam logic [STEP_WIDTH-1:0] STEP_FB_FIRST = 4'd5;
   localparam logic [STEP_WIDTH-1:0] STEP_TAP_X0   = 4'd13;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      OP_SCALE,
      OP_PLAIN,
      OP_SHIFT
   } op_type;

endpackage
`default_nettype wire

/* rtl/iir8_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// iir8 channel interfaces
// Sample, result and register write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface iir8_req_if import iir8_pkg::*; ();
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample;
   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface iir8_rsp_if import iir8_pkg::*; ();
   logic                             valid;
   logic                             ready;
   logic signed [FILTERED_WIDTH-1:0] filtered;
   modport source (output valid, output filtered, input ready);
   modport sink   (input valid, input filtered, output ready);
endinterface

interface iir8_csr_if import iir8_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic [CSR_DATA_WIDTH-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* rtl/iir_eighth_order_bandpass.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// iir_eighth_order_bandpass
// Eighth-order band-pass IIR filter built around one shared multiplier and
// a saturating 64-bit accumulator under a step sequencer.
// Each sample word takes 14 multiplier passes (scaling, five feed-forward
// taps, eight feedback taps), then a drain and an update state, and the
// update waits while a previous word on rsp is not yet taken.
// req is ready again once the result is loaded into the output register.
// Reset clears both histories and the output valid flag and sets the
// coefficients to zero and the reciprocal gain to 1.0.
// ----------------------------------------------------------------------------
module iir_eighth_order_bandpass import iir8_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   iir8_req_if.sink   req_bus,
   iir8_rsp_if.source rsp_bus,
   iir8_csr_if.sink   csr_bus
);

   state_type state_ff, state_in;
   logic [STEP_WIDTH-1:0] step_ff, step_in;

   logic [PAIR_WIDTH-1:0]  coef_ff [4];
   logic [GAIN_WIDTH-1:0]  inv_gain_ff;

   logic signed [STATE_WIDTH-1:0] ih_ff [HIST_DEPTH];
   logic signed [STATE_WIDTH-1:0] oh_ff [HIST_DEPTH];

   logic signed [SAMPLE_WIDTH-1:0]   sample_ff;
   logic signed [FILTERED_WIDTH-1:0] result_ff;
   logic signed [STATE_WIDTH-1:0]    xn_ff;
   logic signed [ACC_WIDTH-1:0]      acc_ff;
   logic signed [PROD_WIDTH-1:0]     prod_ff;
   op_type                           op_ff, op_in;
   logic                             pend_ff;
   logic                             rsp_valid_ff;
   logic signed [FILTERED_WIDTH-1:0] rsp_data_ff;

   logic                             req_fire, finish;
   logic signed [STATE_WIDTH-1:0]    op_a;
   logic signed [MUL_B_WIDTH-1:0]    op_b;
   logic signed [PROD_WIDTH-1:0]     prod_in;
   logic [HIST_IDX_WIDTH-1:0]        fb_idx;
   logic [COEF_WIDTH-1:0]            coef_sel;
   logic signed [PROD_WIDTH-1:0]     scale_round;
   logic signed [STATE_WIDTH-1:0]    xn_in;
   logic signed [EXT_WIDTH-1:0]      term_ext, term_shift;
   logic signed [ACC_WIDTH-1:0]      term;
   logic signed [ACC_WIDTH:0]        sum_wide;
   logic signed [ACC_WIDTH-1:0]      sum_sat;
   logic signed [STATE_WIDTH-1:0]    yn;
   logic signed [ACC_WIDTH-1:0]      res_wide;
   logic signed [FILTERED_WIDTH-1:0] res_sat;

   assign req_bus.ready    = (state_ff == ST_IDLE);
   assign req_fire         = req_bus.valid && req_bus.ready;
   assign csr_bus.ready    = 1'b1;
   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.filtered = rsp_data_ff;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      finish   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_RUN;
               step_in  = STEP_SCALE;
            end
         end
         ST_RUN: begin
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_TAP_X0) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               finish   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      step_ff <= step_in;
   end

   always_comb begin
      fb_idx   = HIST_IDX_WIDTH'(step_ff - STEP_FB_FIRST);
      coef_sel = coef_ff[fb_idx[2:1]][fb_idx[0]*COEF_WIDTH +: COEF_WIDTH];
      op_a     = ih_ff[7];
      op_b     = MUL_B_WIDTH'(TAP_ONE);
      op_in    = OP_PLAIN;
      case (step_ff)
         STEP_SCALE: begin
            op_a  = STATE_WIDTH'(sample_ff);
            op_b  = MUL_B_WIDTH'(inv_gain_ff);
            op_in = OP_SCALE;
         end
         STEP_TAP_X8: begin
            op_a = ih_ff[7];
         end
         STEP_TAP_X2: begin
            op_a = ih_ff[1];
            op_b = MUL_B_WIDTH'(TAP_MINUS_FOUR);
         end
         STEP_TAP_X6: begin
            op_a = ih_ff[5];
            op_b = MUL_B_WIDTH'(TAP_MINUS_FOUR);
         end
         STEP_TAP_X4: begin
            op_a = ih_ff[3];
            op_b = MUL_B_WIDTH'(TAP_SIX);
         end
         STEP_TAP_X0: begin
            op_a = xn_ff;
         end
         default: begin
            op_a  = oh_ff[HIST_IDX_WIDTH'(HIST_DEPTH - 1) - fb_idx];
            op_b  = MUL_B_WIDTH'(signed'(coef_sel));
            op_in = OP_SHIFT;
         end
      endcase
   end

   assign prod_in = op_a * op_b;

   always_comb begin
      scale_round = (prod_ff + ROUND_BIAS) >>> SCALE_SHIFT;
      if (scale_round > PROD_WIDTH'(STATE_MAX)) begin
         xn_in = STATE_MAX;
      end else if (scale_round < PROD_WIDTH'(STATE_MIN)) begin
         xn_in = STATE_MIN;
      end else begin
         xn_in = STATE_WIDTH'(scale_round);
      end

      term_ext   = EXT_WIDTH'(prod_ff);
      term_shift = (op_ff == OP_SHIFT) ? (term_ext >>> FRAC_SHIFT) : term_ext;
      term       = signed'(term_shift[ACC_WIDTH-1:0]);
      sum_wide   = (ACC_WIDTH+1)'(acc_ff) + (ACC_WIDTH+1)'(term);
      if (sum_wide[ACC_WIDTH] != sum_wide[ACC_WIDTH-1]) begin
         sum_sat = {sum_wide[ACC_WIDTH], {(ACC_WIDTH-1){~sum_wide[ACC_WIDTH]}}};
      end else begin
         sum_sat = sum_wide[ACC_WIDTH-1:0];
      end

      if (acc_ff > ACC_WIDTH'(STATE_MAX)) begin
         yn = STATE_MAX;
      end else if (acc_ff < ACC_WIDTH'(STATE_MIN)) begin
         yn = STATE_MIN;
      end else begin
         yn = STATE_WIDTH'(acc_ff);
      end

      res_wide = ACC_WIDTH'(oh_ff[3]);
      if (res_wide > OUT_MAX) begin
         res_sat = FILTERED_WIDTH'(OUT_MAX);
      end else if (res_wide < OUT_MIN) begin
         res_sat = FILTERED_WIDTH'(OUT_MIN);
      end else begin
         res_sat = FILTERED_WIDTH'(res_wide);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      op_ff   <= op_in;
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= (state_ff == ST_RUN);
      end
      if (req_fire) begin
         sample_ff <= req_bus.sample;
         result_ff <= res_sat;
         acc_ff    <= '0;
      end else if (pend_ff) begin
         if (op_ff == OP_SCALE) begin
            xn_ff <= xn_in;
         end else begin
            acc_ff <= sum_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < HIST_DEPTH; k++) begin
            ih_ff[k] <= '0;
            oh_ff[k] <= '0;
         end
      end else if (finish) begin
         for (int k = HIST_DEPTH - 1; k > 0; k--) begin
            ih_ff[k] <= ih_ff[k-1];
            oh_ff[k] <= oh_ff[k-1];
         end
         ih_ff[0] <= xn_ff;
         oh_ff[0] <= yn;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (finish) begin
         rsp_data_ff <= result_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 4; k++) begin
            coef_ff[k] <= '0;
         end
         inv_gain_ff <= INV_GAIN_RESET;
      end else if (csr_bus.valid && csr_bus.ready) begin
         case (csr_bus.index)
            REG_COEF_PAIR_0: coef_ff[0] <= csr_bus.data[PAIR_WIDTH-1:0];
            REG_COEF_PAIR_1: coef_ff[1] <= csr_bus.data[PAIR_WIDTH-1:0];
            REG_COEF_PAIR_2: coef_ff[2] <= csr_bus.data[PAIR_WIDTH-1:0];
            REG_COEF_PAIR_3: coef_ff[3] <= csr_bus.data[PAIR_WIDTH-1:0];
            REG_INV_GAIN:    inv_gain_ff <= csr_bus.data[GAIN_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

endmodule
`default_nettype wire

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the eighth-order band-pass IIR filter. A scoreboard
// class predicts every filtered word from the sample words and register
// writes it sees on the bus. Tasks drive bursty sample traffic and register
// writes between phases that sweep zero, small, random and extreme settings,
// while a separate process makes the result sink stall at random.
// ----------------------------------------------------------------------------
import iir8_pkg::*;

class bandpass_scoreboard;
   logic [PAIR_WIDTH-1:0]           coef_pair [4];
   logic [GAIN_WIDTH-1:0]           inv_gain;
   longint                          x_hist [HIST_DEPTH];
   longint                          y_hist [HIST_DEPTH];
   logic signed [FILTERED_WIDTH-1:0] filtered_due [$];
   int                              errors;
   int                              samples_seen;
   int                              writes_seen;

   function new();
      for (int k = 0; k < 4; k++) coef_pair[k] = '0;
      inv_gain = INV_GAIN_RESET;
      for (int k = 0; k < HIST_DEPTH; k++) begin
         x_hist[k] = 0;
         y_hist[k] = 0;
      end
      errors = 0;
      samples_seen = 0;
      writes_seen = 0;
   endfunction

   function longint clamp_state(longint v);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (STATE_WIDTH - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   function longint clamp_out(longint v);
      if (v > longint'(OUT_MAX)) return longint'(OUT_MAX);
      if (v < longint'(OUT_MIN)) return longint'(OUT_MIN);
      return v;
   endfunction

   function longint add_clamped(longint a, longint b);
      longint sum;
      sum = a + b;
      if (a[63] == b[63] && sum[63] != a[63])
         return a[63] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
      return sum;
   endfunction

   function void update_reg(logic [CSR_INDEX_WIDTH-1:0] index,
                            logic [CSR_DATA_WIDTH-1:0] data);
      writes_seen++;
      case (index)
         REG_COEF_PAIR_0, REG_COEF_PAIR_1, REG_COEF_PAIR_2, REG_COEF_PAIR_3: begin
            coef_pair[index] = data[PAIR_WIDTH-1:0];
         end
         REG_INV_GAIN: begin
            inv_gain = data[GAIN_WIDTH-1:0];
         end
         default: begin
         end
      endcase
   endfunction

   function logic signed [FILTERED_WIDTH-1:0] filter_next(logic signed [SAMPLE_WIDTH-1:0] sample);
      longint s;
      longint g;
      longint xn;
      longint acc;
      longint c;
      longint prev;
      logic signed [COEF_WIDTH-1:0] coef;
      s = sample;
      g = longint'({32'b0, inv_gain});
      xn = clamp_state((s * g + 8192) >>> SCALE_SHIFT);
      acc = xn + x_hist[7] - 4 * (x_hist[1] + x_hist[5]) + 6 * x_hist[3];
      for (int i = 0; i < HIST_DEPTH; i++) begin
         coef = coef_pair[i / 2][(i % 2) * COEF_WIDTH +: COEF_WIDTH];
         c = coef;
         acc = add_clamped(acc, (y_hist[7 - i] * c) >>> FRAC_SHIFT);
      end
      prev = y_hist[3];
      for (int k = HIST_DEPTH - 1; k > 0; k--) begin
         x_hist[k] = x_hist[k - 1];
         y_hist[k] = y_hist[k - 1];
      end
      x_hist[0] = xn;
      y_hist[0] = clamp_state(acc);
      return FILTERED_WIDTH'(clamp_out(prev));
   endfunction

   function void accept_sample(logic signed [SAMPLE_WIDTH-1:0] sample);
      samples_seen++;
      filtered_due.push_back(filter_next(sample));
   endfunction

   function void check_filtered(logic signed [FILTERED_WIDTH-1:0] actual);
      logic signed [FILTERED_WIDTH-1:0] expected;
      if (filtered_due.size() == 0) begin
         errors++;
         if (errors <= 20)
            $display("%0t: unexpected filtered word, expected none, actual %0d",
                     $time, actual);
         return;
      end
      expected = filtered_due.pop_front();
      if (expected !== actual) begin
         errors++;
         if (errors <= 20)
            $display("%0t: filtered mismatch, expected %0d, actual %0d",
                     $time, expected, actual);
      end
   endfunction
endclass

module tb_top;

   typedef enum int {
      CFG_FIR_ONLY,
      CFG_SMALL_FEEDBACK,
      CFG_RANDOM_FULL,
      CFG_EXTREME
   } cfg_mode_type;

   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset;

   iir8_req_if req_bus ();
   iir8_rsp_if rsp_bus ();
   iir8_csr_if csr_bus ();

   iir_eighth_order_bandpass u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   bandpass_scoreboard sb = new();

   int cycles = 0;
   int hold_left = 0;
   int hold_kind = 0;
   int settings_used = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d words outstanding",
                  cycles, sb.filtered_due.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) sb.check_filtered(rsp_bus.filtered);
         if (req_bus.valid && req_bus.ready) sb.accept_sample(req_bus.sample);
         if (csr_bus.valid && csr_bus.ready) sb.update_reg(csr_bus.index, csr_bus.data);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (hold_left == 0) begin
            hold_kind = $urandom_range(0, 3);
            hold_left = (hold_kind == 0) ? $urandom_range(20, 80) : $urandom_range(1, 30);
         end
         hold_left = hold_left - 1;
         case (hold_kind)
            0: rsp_bus.ready <= 1'b1;
            1: rsp_bus.ready <= 1'b0;
            default: rsp_bus.ready <= 1'($urandom_range(0, 1));
         endcase
      end
   end

   task automatic push_sample(input logic signed [SAMPLE_WIDTH-1:0] sample);
      req_bus.valid  <= 1'b1;
      req_bus.sample <= sample;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic idle_sender(input int gap);
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (sb.filtered_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic signed [SAMPLE_WIDTH-1:0] random_sample();
      case ($urandom_range(0, 5))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return SAMPLE_WIDTH'($signed($urandom_range(0, 64)) - 32);
         default: return SAMPLE_WIDTH'($urandom);
      endcase
   endfunction

   function automatic logic [COEF_WIDTH-1:0] pick_coef(input cfg_mode_type mode);
      case (mode)
         CFG_FIR_ONLY: return '0;
         CFG_SMALL_FEEDBACK: return COEF_WIDTH'($signed($urandom_range(0, 8192)) - 4096);
         CFG_RANDOM_FULL: return COEF_WIDTH'($urandom);
         default: begin
            case ($urandom_range(0, 3))
               0: return 24'h7F_FFFF;
               1: return 24'h80_0000;
               2: return 24'h00_0001;
               default: return 24'hFF_FFFF;
            endcase
         end
      endcase
   endfunction

   function automatic logic [CSR_DATA_WIDTH-1:0] pick_gain(input cfg_mode_type mode);
      logic [CSR_DATA_WIDTH-1:0] upper;
      upper = CSR_DATA_WIDTH'($urandom) << GAIN_WIDTH;
      case (mode)
         CFG_FIR_ONLY: return CSR_DATA_WIDTH'($urandom);
         CFG_SMALL_FEEDBACK: return CSR_DATA_WIDTH'($urandom_range(1 << 26, 1 << 30));
         CFG_RANDOM_FULL: return upper | CSR_DATA_WIDTH'($urandom);
         default: begin
            case ($urandom_range(0, 2))
               0: return upper;
               1: return upper | CSR_DATA_WIDTH'(32'hFFFF_FFFF);
               default: return CSR_DATA_WIDTH'(INV_GAIN_RESET);
            endcase
         end
      endcase
   endfunction

   task automatic apply_setting(input cfg_mode_type mode);
      wait_drained();
      for (int k = 0; k < 4; k++)
         write_reg(REG_COEF_PAIR_0 + CSR_INDEX_WIDTH'(k),
                   CSR_DATA_WIDTH'({pick_coef(mode), pick_coef(mode)}));
      write_reg(REG_INV_GAIN, pick_gain(mode));
      if ($urandom_range(0, 2) == 0)
         write_reg(REG_INV_GAIN + CSR_INDEX_WIDTH'($urandom_range(1, 3)),
                   CSR_DATA_WIDTH'({$urandom, 16'($urandom)}));
      settings_used++;
   endtask

   task automatic run_bursts(input int count);
      int left;
      int burst;
      left = count;
      while (left > 0) begin
         burst = $urandom_range(1, 16);
         if ($urandom_range(0, 4) == 0) burst = 30;
         if (burst > left) burst = left;
         repeat (burst) push_sample(random_sample());
         left = left - burst;
         if ($urandom_range(0, 39) == 0) wait_drained();
         else if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 40));
      end
   endtask

   initial begin
      cfg_mode_type mode;
      reset = 1'b1;
      req_bus.valid  = 1'b0;
      req_bus.sample = '0;
      csr_bus.valid  = 1'b0;
      csr_bus.index  = '0;
      csr_bus.data   = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset values: unity gain, no feedback.
      push_sample(16'sh7FFF);
      push_sample(16'sh8000);
      push_sample(16'sh0000);
      push_sample(16'sh0001);
      push_sample(16'shFFFF);
      push_sample(16'sh5555);
      push_sample(16'shAAAA);
      push_sample(16'sh0064);
      repeat (4) push_sample(16'sh0000);

      // Full-scale gain saturates the scaled input; upper data bits and
      // unknown indexes must have no effect.
      wait_drained();
      write_reg(REG_INV_GAIN, {16'hFFFF, 32'hFFFF_FFFF});
      for (int k = 1; k <= 3; k++)
         write_reg(REG_INV_GAIN + CSR_INDEX_WIDTH'(k), {CSR_DATA_WIDTH{1'b1}});
      push_sample(16'sh7FFF);
      push_sample(16'sh8000);
      push_sample(16'sh7FFF);
      push_sample(16'sh8000);
      push_sample(16'sh0001);
      push_sample(16'shFFFF);

      // Extreme feedback drives the accumulator and history to saturation.
      wait_drained();
      write_reg(REG_COEF_PAIR_0, {24'h80_0000, 24'h7F_FFFF});
      write_reg(REG_COEF_PAIR_1, {24'h7F_FFFF, 24'h80_0000});
      write_reg(REG_COEF_PAIR_2, {24'h7F_FFFF, 24'h7F_FFFF});
      write_reg(REG_COEF_PAIR_3, {24'h80_0000, 24'h80_0000});
      write_reg(REG_INV_GAIN, '0);
      repeat (3) push_sample(16'sh7FFF);
      push_sample(16'sh8000);
      settings_used = 3;

      for (int phase = 0; phase < 8; phase++) begin
         if (phase < 4) mode = cfg_mode_type'(phase);
         else if ($urandom_range(0, 1) == 0) mode = CFG_SMALL_FEEDBACK;
         else mode = cfg_mode_type'($urandom_range(0, 3));
         apply_setting(mode);
         run_bursts($urandom_range(50, 75));
      end

      wait_drained();
      repeat (30) @(posedge clock);
      if (sb.filtered_due.size() != 0) begin
         sb.errors++;
         $display("%0t: %0d filtered words never arrived", $time, sb.filtered_due.size());
      end
      $display("Run covered %0d sample words and %0d register writes over %0d settings,",
               sb.samples_seen, sb.writes_seen, settings_used);
      $display("from plain FIR to saturating feedback, with bursty input and output stalls.");
      if (sb.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
